@@ rtl/tcs_pkg.sv @@
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, constants and saturating helpers for the triangle stress path.
// ----------------------------------------------------------------------------
package tcs_pkg;

    // Wide width used for saturation of any intermediate
    localparam int SAT_W = 72;

    localparam logic signed [31:0] QMAX    = 32'sh7fffffff;
    localparam logic signed [15:0] OUT_ONE = 16'sd16384;

    localparam logic signed [SAT_W-1:0] SAT_HI = 72'sd2147483647;
    localparam logic signed [SAT_W-1:0] SAT_LO = -72'sd2147483647;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SHEAR = 2'd0,
        CFG_LAMBDA = 2'd1,
        CFG_DAMP = 2'd2,
        CFG_SCALE = 2'd3
    } t_cfg_idx;

    // Input word: edge vectors of initial shape, current shape and velocity
    typedef struct packed {
        logic signed [31:0] init_e1_x;
        logic signed [31:0] init_e1_y;
        logic signed [31:0] init_e2_x;
        logic signed [31:0] init_e2_y;
        logic signed [31:0] cur_e1_x;
        logic signed [31:0] cur_e1_y;
        logic signed [31:0] cur_e2_x;
        logic signed [31:0] cur_e2_y;
        logic signed [31:0] vel_e1_x;
        logic signed [31:0] vel_e1_y;
        logic signed [31:0] vel_e2_x;
        logic signed [31:0] vel_e2_y;
    } t_in_word;

    // Output word: normalized stress in Q2.14 and degenerate flag
    typedef struct packed {
        logic signed [15:0] stress_xx;
        logic signed [15:0] stress_yy;
        logic signed [15:0] stress_xy;
        logic               degenerate;
    } t_out_word;

    // Clamp to [-(2^31-1), 2^31-1]
    function automatic logic signed [31:0] f_sat(input logic signed [SAT_W-1:0] x);
        if (x > SAT_HI) begin
            return QMAX;
        end else if (x < SAT_LO) begin
            return -QMAX;
        end else begin
            return x[31:0];
        end
    endfunction

    function automatic logic signed [31:0] f_sat33(input logic signed [32:0] x);
        return f_sat({{(SAT_W-33){x[32]}}, x});
    endfunction

    function automatic logic signed [32:0] f_sx33(input logic signed [31:0] x);
        return {x[31], x};
    endfunction

    function automatic logic signed [32:0] f_zx33(input logic [30:0] x);
        return {2'b00, x};
    endfunction

    function automatic logic signed [32:0] f_neg33(input logic signed [31:0] x);
        return -f_sx33(x);
    endfunction

    // (a + b) / 2 rounded to nearest, halves up
    function automatic logic signed [31:0] f_half_sum(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [33:0] s;
        s = $signed({{2{a[31]}}, a}) + $signed({{2{b[31]}}, b}) + 34'sd1;
        return s[32:1];
    endfunction

endpackage

@@ rtl/tcs_dly.sv @@
// ----------------------------------------------------------------------------
// tcs_dly
// Enabled delay line that carries a word alongside the pipeline.
// ----------------------------------------------------------------------------
module tcs_dly #(
    parameter int W = 32,
    parameter int D = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [D];

    // Shift the word one stage per advance
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_q = r_pipe[D-1];

endmodule

@@ rtl/tcs_dot.sv @@
// ----------------------------------------------------------------------------
// tcs_dot
// Two-stage fixed-point dot product a*b + c*d, rounded once and saturated.
// ----------------------------------------------------------------------------
module tcs_dot
    import tcs_pkg::*;
#(
    parameter int FB = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    input  logic signed [32:0] i_c,
    input  logic signed [32:0] i_d,
    output logic signed [31:0] o_q
);

    localparam logic signed [67:0] HALF = (68'sd1 <<< FB) >>> 1;

    logic signed [65:0] r_p1;
    logic signed [65:0] r_p2;
    logic signed [67:0] w_sum;
    logic signed [67:0] w_shr;
    logic signed [31:0] r_q;

    // Multiply both pairs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= i_a * i_b;
            r_p2 <= i_c * i_d;
        end
    end

    // Add, round halves up, saturate
    always_comb begin
        w_sum = $signed({{2{r_p1[65]}}, r_p1}) + $signed({{2{r_p2[65]}}, r_p2}) + HALF;
        w_shr = w_sum >>> FB;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= f_sat({{(SAT_W-68){w_shr[67]}}, w_shr});
        end
    end

    assign o_q = r_q;

endmodule

@@ rtl/tcs_div.sv @@
// ----------------------------------------------------------------------------
// tcs_div
// Pipelined fixed-point divider: (num << FB) / den, rounded half away from
// zero, saturated. One quotient bit per stage.
// ----------------------------------------------------------------------------
module tcs_div
    import tcs_pkg::*;
#(
    parameter int FB = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [32:0] i_num,
    input  logic signed [31:0] i_den,
    output logic signed [31:0] o_quo
);

    localparam int QB = 31;
    localparam int NW = 34 + FB;
    localparam int RW = (NW > 63) ? NW : 63;

    logic [32:0]   w_un;
    logic [31:0]   w_ub;
    logic [RW-1:0] w_n;
    logic          w_ovf;

    logic [RW-1:0] r_rem [QB+1];
    logic [31:0]   r_ub  [QB+1];
    logic [QB-1:0] r_quo [QB+1];
    logic [QB:0]   r_neg;
    logic [QB:0]   r_ovf;

    logic [30:0]        w_mag;
    logic signed [31:0] r_q;

    // Take magnitudes, add half divisor, flag quotients past full scale
    always_comb begin
        w_un  = i_num[32] ? -i_num : i_num;
        w_ub  = i_den[31] ? -i_den : i_den;
        w_n   = (RW'(w_un) << FB) + RW'(w_ub[31:1]);
        w_ovf = w_n >= (RW'(w_ub) << QB);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_n;
            r_ub[0]  <= w_ub;
            r_quo[0] <= '0;
            r_neg[0] <= i_num[32] ^ i_den[31];
            r_ovf[0] <= w_ovf;
        end
    end

    // One restoring step per stage, most significant bit first
    for (genvar s = 1; s <= QB; s++) begin : g_step
        localparam int K = QB - s;
        logic [RW-1:0] w_sh;
        logic          w_ge;

        always_comb begin
            w_sh = RW'(r_ub[s-1]) << K;
            w_ge = r_rem[s-1] >= w_sh;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? (r_rem[s-1] - w_sh) : r_rem[s-1];
                r_quo[s] <= r_quo[s-1] | (QB'(w_ge) << K);
                r_ub[s]  <= r_ub[s-1];
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    // Saturate and restore sign
    assign w_mag = r_ovf[QB] ? QMAX[30:0] : r_quo[QB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= r_neg[QB] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        end
    end

    assign o_quo = r_q;

endmodule

@@ rtl/triangle_cauchy_stress.sv @@
// ----------------------------------------------------------------------------
// triangle_cauchy_stress
// Throughput: one word per cycle unless stalled; 33-stage dividers set the depth.
// Stall freezes the pipeline only when the output word is held and another
// finished word waits behind it; every slot, empty or not, holds meanwhile.
// Reset clears the valid bits and loads the registers with 0, 0, 0, 65536.
// ----------------------------------------------------------------------------
module triangle_cauchy_stress
    import tcs_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_word    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_word   o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    // Stage times, counted from the input register
    localparam int LD   = 33;
    localparam int T_DT = 2;
    localparam int T1   = T_DT + LD;
    localparam int T2   = T1 + 2;
    localparam int T3   = T2 + 2;
    localparam int T4   = T3 + 1;
    localparam int T5   = T4 + 2;
    localparam int T_S  = T5 + 7;
    localparam int T_V  = T1 + 3;

    localparam logic signed [32:0] ONE = 33'sd1 <<< FRACTION_BITS;

    localparam int SH_R = (FRACTION_BITS >= 14) ? FRACTION_BITS - 14 : 0;
    localparam int SH_L = (FRACTION_BITS < 14) ? 14 - FRACTION_BITS : 0;
    localparam logic signed [47:0] HALF48 = (48'sd1 <<< SH_R) >>> 1;

    // Configuration registers
    logic [30:0] r_mu;
    logic [30:0] r_lam;
    logic [30:0] r_visc;
    logic [30:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu    <= '0;
            r_lam   <= '0;
            r_visc  <= '0;
            r_scale <= 31'd65536;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SHEAR:  r_mu    <= i_cfg_data;
                CFG_LAMBDA: r_lam   <= i_cfg_data;
                CFG_DAMP:   r_visc  <= i_cfg_data;
                CFG_SCALE:  r_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance: hold only when a finished word cannot leave
    logic          w_adv;
    logic          r_in_vld;
    t_in_word      r_in;
    logic [T_S-1:0] r_vld;
    logic          r_out_vld;
    t_out_word     r_out;

    assign w_adv   = !(r_out_vld && i_stall && r_vld[T_S-1]);
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_vld    <= '0;
        end else if (w_adv) begin
            r_in_vld <= i_valid;
            r_vld    <= {r_vld[T_S-2:0], r_in_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in <= i_data;
        end
    end

    // Determinants of both edge matrices
    logic signed [31:0] w_det_i;
    logic signed [31:0] w_det_c;

    tcs_dot #(.FB(FRACTION_BITS)) u_det_i (
        .i_clk(i_clk), .i_en(w_adv),
        .i_a(f_sx33(r_in.init_e1_x)), .i_b(f_sx33(r_in.init_e2_y)),
        .i_c(f_neg33(r_in.init_e2_x)), .i_d(f_sx33(r_in.init_e1_y)),
        .o_q(w_det_i)
    );

    tcs_dot #(.FB(FRACTION_BITS)) u_det_c (
        .i_clk(i_clk), .i_en(w_adv),
        .i_a(f_sx33(r_in.cur_e1_x)), .i_b(f_sx33(r_in.cur_e2_y)),
        .i_c(f_neg33(r_in.cur_e2_x)), .i_d(f_sx33(r_in.cur_e1_y)),
        .o_q(w_det_c)
    );

    // Align the edge vectors with the determinants
    logic [255:0] w_x2;
    logic signed [31:0] w_ie1x, w_ie1y, w_ie2x, w_ie2y;
    logic signed [31:0] w_ce1x, w_ce1y, w_ce2x, w_ce2y;

    tcs_dly #(.W(256), .D(T_DT)) u_dly_x (
        .i_clk(i_clk), .i_en(w_adv),
        .i_d({r_in.init_e1_x, r_in.init_e1_y, r_in.init_e2_x, r_in.init_e2_y,
              r_in.cur_e1_x, r_in.cur_e1_y, r_in.cur_e2_x, r_in.cur_e2_y}),
        .o_q(w_x2)
    );

    assign w_ie1x = w_x2[255:224];
    assign w_ie1y = w_x2[223:192];
    assign w_ie2x = w_x2[191:160];
    assign w_ie2y = w_x2[159:128];
    assign w_ce1x = w_x2[127:96];
    assign w_ce1y = w_x2[95:64];
    assign w_ce2x = w_x2[63:32];
    assign w_ce2y = w_x2[31:0];

    // Inverse entries of both matrices and the two determinant ratios
    logic signed [32:0] w_dnum [10];
    logic signed [31:0] w_dden [10];
    logic signed [31:0] w_dquo [10];

    always_comb begin
        w_dnum[0] = f_sx33(w_ie2y);  w_dden[0] = w_det_i;
        w_dnum[1] = f_neg33(w_ie2x); w_dden[1] = w_det_i;
        w_dnum[2] = f_neg33(w_ie1y); w_dden[2] = w_det_i;
        w_dnum[3] = f_sx33(w_ie1x);  w_dden[3] = w_det_i;
        w_dnum[4] = f_sx33(w_ce2y);  w_dden[4] = w_det_c;
        w_dnum[5] = f_neg33(w_ce2x); w_dden[5] = w_det_c;
        w_dnum[6] = f_neg33(w_ce1y); w_dden[6] = w_det_c;
        w_dnum[7] = f_sx33(w_ce1x);  w_dden[7] = w_det_c;
        w_dnum[8] = f_sx33(w_det_i); w_dden[8] = w_det_c;
        w_dnum[9] = f_sx33(w_det_c); w_dden[9] = w_det_i;
    end

    for (genvar n = 0; n < 10; n++) begin : g_div
        tcs_div #(.FB(FRACTION_BITS)) u_div (
            .i_clk(i_clk), .i_en(w_adv),
            .i_num(w_dnum[n]), .i_den(w_dden[n]), .o_quo(w_dquo[n])
        );
    end

    // Degenerate flag travels to the output stage
    logic w_deg;

    tcs_dly #(.W(1), .D(T_S - T_DT)) u_dly_deg (
        .i_clk(i_clk), .i_en(w_adv),
        .i_d(w_det_i == 32'sd0 || w_det_c == 32'sd0),
        .o_q(w_deg)
    );

    // Current and velocity edges aligned with the inverses
    logic [127:0] w_cd;
    logic [127:0] w_vd;
    logic signed [31:0] w_c1x, w_c1y, w_c2x, w_c2y;
    logic signed [31:0] w_v1x, w_v1y, w_v2x, w_v2y;

    tcs_dly #(.W(128), .D(LD)) u_dly_c (
        .i_clk(i_clk), .i_en(w_adv), .i_d(w_x2[127:0]), .o_q(w_cd)
    );

    tcs_dly #(.W(128), .D(T1)) u_dly_v (
        .i_clk(i_clk), .i_en(w_adv),
        .i_d({r_in.vel_e1_x, r_in.vel_e1_y, r_in.vel_e2_x, r_in.vel_e2_y}),
        .o_q(w_vd)
    );

    assign w_c1x = w_cd[127:96];
    assign w_c1y = w_cd[95:64];
    assign w_c2x = w_cd[63:32];
    assign w_c2y = w_cd[31:0];
    assign w_v1x = w_vd[127:96];
    assign w_v1y = w_vd[95:64];
    assign w_v2x = w_vd[63:32];
    assign w_v2y = w_vd[31:0];

    // Deformation gradient F and velocity gradient L, entries 00 01 10 11
    logic signed [31:0] w_f [4];
    logic signed [31:0] w_l [4];

    for (genvar q = 0; q < 4; q++) begin : g_fl
        localparam int RI = q / 2;
        localparam int CJ = q % 2;
        tcs_dot #(.FB(FRACTION_BITS)) u_f (
            .i_clk(i_clk), .i_en(w_adv),
            .i_a(f_sx33(RI == 0 ? w_c1x : w_c1y)), .i_b(f_sx33(w_dquo[CJ])),
            .i_c(f_sx33(RI == 0 ? w_c2x : w_c2y)), .i_d(f_sx33(w_dquo[2 + CJ])),
            .o_q(w_f[q])
        );
        tcs_dot #(.FB(FRACTION_BITS)) u_l (
            .i_clk(i_clk), .i_en(w_adv),
            .i_a(f_sx33(RI == 0 ? w_v1x : w_v1y)), .i_b(f_sx33(w_dquo[4 + CJ])),
            .i_c(f_sx33(RI == 0 ? w_v2x : w_v2y)), .i_d(f_sx33(w_dquo[6 + CJ])),
            .o_q(w_l[q])
        );
    end

    // Volumetric term lambda * (1/r - r)
    logic signed [31:0] r_rdiff;
    logic signed [31:0] w_vol;
    logic signed [31:0] w_vol_d;
    logic signed [31:0] w_r_d;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rdiff <= f_sat33(f_sx33(w_dquo[9]) - f_sx33(w_dquo[8]));
        end
    end

    tcs_dot #(.FB(FRACTION_BITS)) u_vol (
        .i_clk(i_clk), .i_en(w_adv),
        .i_a(f_zx33(r_lam)), .i_b(f_sx33(r_rdiff)),
        .i_c('0), .i_d('0), .o_q(w_vol)
    );

    tcs_dly #(.W(32), .D(T5 + 4 - T_V)) u_dly_vol (
        .i_clk(i_clk), .i_en(w_adv), .i_d(w_vol), .o_q(w_vol_d)
    );

    tcs_dly #(.W(32), .D(T5 + 1 - T1)) u_dly_r (
        .i_clk(i_clk), .i_en(w_adv), .i_d(w_dquo[8]), .o_q(w_r_d)
    );

    // Per component: 0 xx, 1 yy, 2 xy
    logic signed [31:0] w_b   [3];
    logic signed [31:0] w_dc  [3];
    logic signed [31:0] w_dd  [3];
    logic signed [31:0] r_e   [3];
    logic signed [31:0] w_m1  [3];
    logic signed [31:0] w_kd  [3];
    logic signed [31:0] w_kdd [3];
    logic signed [31:0] r_term[3];
    logic signed [31:0] w_tr  [3];
    logic signed [31:0] r_t   [3];
    logic signed [31:0] r_t2  [3];
    logic signed [31:0] w_s   [3];
    logic signed [15:0] w_o   [3];

    // Left Cauchy-Green tensor B = F F^T
    tcs_dot #(.FB(FRACTION_BITS)) u_b00 (
        .i_clk(i_clk), .i_en(w_adv),
        .i_a(f_sx33(w_f[0])), .i_b(f_sx33(w_f[0])),
        .i_c(f_sx33(w_f[1])), .i_d(f_sx33(w_f[1])), .o_q(w_b[0])
    );
    tcs_dot #(.FB(FRACTION_BITS)) u_b11 (
        .i_clk(i_clk), .i_en(w_adv),
        .i_a(f_sx33(w_f[2])), .i_b(f_sx33(w_f[2])),
        .i_c(f_sx33(w_f[3])), .i_d(f_sx33(w_f[3])), .o_q(w_b[1])
    );
    tcs_dot #(.FB(FRACTION_BITS)) u_b01 (
        .i_clk(i_clk), .i_en(w_adv),
        .i_a(f_sx33(w_f[0])), .i_b(f_sx33(w_f[2])),
        .i_c(f_sx33(w_f[1])), .i_d(f_sx33(w_f[3])), .o_q(w_b[2])
    );

    // Stretching rate D = (L + L^T) / 2
    assign w_dc[0] = f_half_sum(w_l[0], w_l[0]);
    assign w_dc[1] = f_half_sum(w_l[3], w_l[3]);
    assign w_dc[2] = f_half_sum(w_l[1], w_l[2]);

    for (genvar k = 0; k < 3; k++) begin : g_comp
        localparam logic signed [32:0] DIAG_ONE = (k < 2) ? ONE : 33'sd0;

        tcs_dly #(.W(32), .D(T4 - T2)) u_dly_d (
            .i_clk(i_clk), .i_en(w_adv), .i_d(w_dc[k]), .o_q(w_dd[k])
        );

        // Strain E = (B - I) / 2
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_e[k] <= f_half_sum(f_sat33(f_sx33(w_b[k]) - DIAG_ONE), 32'sd0);
            end
        end

        tcs_dot #(.FB(FRACTION_BITS)) u_mu (
            .i_clk(i_clk), .i_en(w_adv),
            .i_a(f_zx33(r_mu)), .i_b(f_sx33(r_e[k])),
            .i_c('0), .i_d('0), .o_q(w_m1[k])
        );

        tcs_dot #(.FB(FRACTION_BITS)) u_visc (
            .i_clk(i_clk), .i_en(w_adv),
            .i_a(f_zx33(r_visc)), .i_b(f_sx33(w_dd[k])),
            .i_c('0), .i_d('0), .o_q(w_kd[k])
        );

        // Double the shear term
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_term[k] <= f_sat33({w_m1[k], 1'b0});
            end
        end

        tcs_dot #(.FB(FRACTION_BITS)) u_ratio (
            .i_clk(i_clk), .i_en(w_adv),
            .i_a(f_sx33(r_term[k])), .i_b(f_sx33(w_r_d)),
            .i_c('0), .i_d('0), .o_q(w_tr[k])
        );

        tcs_dly #(.W(32), .D(3)) u_dly_kd (
            .i_clk(i_clk), .i_en(w_adv), .i_d(w_kd[k]), .o_q(w_kdd[k])
        );

        // Sum shear and viscous terms; add the volumetric term to xx and yy only
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_t[k]  <= f_sat33(f_sx33(w_tr[k]) + f_sx33(w_kdd[k]));
                r_t2[k] <= (k < 2) ? f_sat33(f_sx33(r_t[k]) + f_sx33(w_vol_d)) : r_t[k];
            end
        end

        tcs_dot #(.FB(FRACTION_BITS)) u_scale (
            .i_clk(i_clk), .i_en(w_adv),
            .i_a(f_sx33(r_t2[k])), .i_b(f_zx33(r_scale)),
            .i_c('0), .i_d('0), .o_q(w_s[k])
        );

        // Convert to Q2.14 and clamp to plus or minus one
        logic signed [47:0] w_v48;
        logic signed [47:0] w_sc;

        always_comb begin
            w_v48 = {{16{w_s[k][31]}}, w_s[k]};
            w_sc  = ((w_v48 <<< SH_L) + HALF48) >>> SH_R;
            if (w_sc > 48'sd16384) begin
                w_o[k] = OUT_ONE;
            end else if (w_sc < -48'sd16384) begin
                w_o[k] = -OUT_ONE;
            end else begin
                w_o[k] = w_sc[15:0];
            end
        end
    end

    // Output register: load when empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || !i_stall) begin
            r_out_vld <= r_vld[T_S-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || !i_stall) begin
            r_out.stress_xx  <= w_deg ? 16'sd0 : w_o[0];
            r_out.stress_yy  <= w_deg ? 16'sd0 : w_o[1];
            r_out.stress_xy  <= w_deg ? 16'sd0 : w_o[2];
            r_out.degenerate <= w_deg;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // Degenerate words carry zero stress
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |->
            o_data.stress_xx == 16'sd0 && o_data.stress_yy == 16'sd0 &&
            o_data.stress_xy == 16'sd0)
        else $error("degenerate word with nonzero stress");

    // Stress stays within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            o_data.stress_xx <= OUT_ONE && o_data.stress_xx >= -OUT_ONE &&
            o_data.stress_yy <= OUT_ONE && o_data.stress_yy >= -OUT_ONE &&
            o_data.stress_xy <= OUT_ONE && o_data.stress_xy >= -OUT_ONE)
        else $error("stress out of range");

    // Input holds off only behind a blocked output word
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with free output");

endmodule

@@ verif/tb_triangle_cauchy_stress.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_cauchy_stress
// Streams triangles into the stress pipeline under several material settings
// and handshake pressure levels. Every accepted word is predicted in fixed
// point here, and each output word is checked in order against the prediction.
// ----------------------------------------------------------------------------
module tb_triangle_cauchy_stress;
    import tcs_pkg::*;

    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [127:0] t_wide;
    localparam t_wide LIM31 = 128'sd2147483647;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_word    in_data;
    logic        out_valid;
    logic        out_stall;
    t_out_word   out_data;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [30:0] cfg_data;

    // material copy used for prediction
    logic [30:0] mu_q, lambda_q, damp_q, scale_q;

    t_in_word  pending_words[$];
    t_out_word stress_expected[$];
    int        idle_pct, stall_pct;
    bit        hold_req;
    int        errors;
    int        cycles;

    triangle_cauchy_stress uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_data),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- fixed-point predictor ----------------
    function automatic t_wide clamp31(t_wide x);
        if (x > LIM31) return LIM31;
        if (x < -LIM31) return -LIM31;
        return x;
    endfunction

    function automatic t_wide round_shift(t_wide x, int s);
        if (s == 0) return x;
        return (x + (t_wide'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic t_wide fx_dot(t_wide a, t_wide b, t_wide c, t_wide d);
        return clamp31(round_shift(a * b + c * d, FRAC));
    endfunction

    function automatic t_wide fx_mul(t_wide a, t_wide b);
        return fx_dot(a, b, 0, 0);
    endfunction

    function automatic t_wide fx_div(t_wide a, t_wide b);
        t_wide num, un, ub, q;
        bit    neg;
        num = a <<< FRAC;
        neg = (num < 0) != (b < 0);
        un = (num < 0) ? -num : num;
        ub = (b < 0) ? -b : b;
        q = (un + ub / 2) / ub;
        if (q > LIM31) q = LIM31;
        return neg ? -q : q;
    endfunction

    function automatic logic signed [15:0] to_q14(t_wide v);
        t_wide o;
        o = round_shift(v, FRAC - 14);
        if (o > 16384) o = 16384;
        if (o < -16384) o = -16384;
        return o[15:0];
    endfunction

    // inverse of [[a b][c d]], returns rounded determinant
    function automatic t_wide invert_edges(t_wide a, t_wide b, t_wide c, t_wide d,
                                           output t_wide ia, output t_wide ib,
                                           output t_wide ic, output t_wide id);
        t_wide det;
        det = fx_dot(a, d, -b, c);
        ia = 0; ib = 0; ic = 0; id = 0;
        if (det != 0) begin
            ia = fx_div(d, det);
            ib = fx_div(-b, det);
            ic = fx_div(-c, det);
            id = fx_div(a, det);
        end
        return det;
    endfunction

    function automatic t_out_word predict_stress(t_in_word w);
        t_wide     xi[2][2], xc[2][2], vl[2][2], ii[2][2], ic[2][2];
        t_wide     f[2][2], l[2][2], b[2][2], t[2][2];
        t_wide     deti, detc, r, rinv, vol, e, d, term, one;
        t_out_word res;
        xi[0][0] = w.init_e1_x; xi[1][0] = w.init_e1_y;
        xi[0][1] = w.init_e2_x; xi[1][1] = w.init_e2_y;
        xc[0][0] = w.cur_e1_x;  xc[1][0] = w.cur_e1_y;
        xc[0][1] = w.cur_e2_x;  xc[1][1] = w.cur_e2_y;
        vl[0][0] = w.vel_e1_x;  vl[1][0] = w.vel_e1_y;
        vl[0][1] = w.vel_e2_x;  vl[1][1] = w.vel_e2_y;
        deti = invert_edges(xi[0][0], xi[0][1], xi[1][0], xi[1][1],
                            ii[0][0], ii[0][1], ii[1][0], ii[1][1]);
        detc = invert_edges(xc[0][0], xc[0][1], xc[1][0], xc[1][1],
                            ic[0][0], ic[0][1], ic[1][0], ic[1][1]);
        res = '0;
        if (deti == 0 || detc == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++) begin
                f[i][j] = fx_dot(xc[i][0], ii[0][j], xc[i][1], ii[1][j]);
                l[i][j] = fx_dot(vl[i][0], ic[0][j], vl[i][1], ic[1][j]);
            end
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                b[i][j] = fx_dot(f[i][0], f[j][0], f[i][1], f[j][1]);
        r = fx_div(deti, detc);
        rinv = fx_div(detc, deti);
        vol = fx_mul(t_wide'(lambda_q), clamp31(rinv - r));
        one = t_wide'(1) <<< FRAC;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++) begin
                e = round_shift(clamp31(b[i][j] - ((i == j) ? one : 0)), 1);
                d = round_shift(l[i][j] + l[j][i], 1);
                term = clamp31(2 * fx_mul(t_wide'(mu_q), e));
                term = fx_mul(term, r);
                t[i][j] = clamp31(term + fx_mul(t_wide'(damp_q), d));
                if (i == j) t[i][j] = clamp31(t[i][j] + vol);
            end
        res.stress_xx = to_q14(fx_mul(t[0][0], t_wide'(scale_q)));
        res.stress_yy = to_q14(fx_mul(t[1][1], t_wide'(scale_q)));
        res.stress_xy = to_q14(fx_mul(t[0][1], t_wide'(scale_q)));
        return res;
    endfunction

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            // record prediction for the word taken at this edge
            if (in_valid && !in_stall) stress_expected.push_back(predict_stress(in_data));
            if (!in_valid || !in_stall) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= pending_words.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver stall, with one long hold-off ----------------
    int  hold_left = 0;
    bit  hold_seen = 0;
    always @(posedge i_clk) begin
        if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= 300;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (stress_expected.size() == 0) begin
                $display("%0t: unexpected word %h", $time, out_data);
                errors++;
            end else begin
                want = stress_expected.pop_front();
                if (out_data.stress_xx !== want.stress_xx)
                    $display("%0t: stress_xx expected %0d actual %0d", $time,
                             want.stress_xx, out_data.stress_xx);
                if (out_data.stress_yy !== want.stress_yy)
                    $display("%0t: stress_yy expected %0d actual %0d", $time,
                             want.stress_yy, out_data.stress_yy);
                if (out_data.stress_xy !== want.stress_xy)
                    $display("%0t: stress_xy expected %0d actual %0d", $time,
                             want.stress_xy, out_data.stress_xy);
                if (out_data.degenerate !== want.degenerate)
                    $display("%0t: degenerate expected %0b actual %0b", $time,
                             want.degenerate, out_data.degenerate);
                if (out_data !== want) errors++;
            end
        end
    end

    // ---------------- run limit ----------------
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic write_reg(t_cfg_idx idx, logic [30:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            CFG_SHEAR:  mu_q = val;
            CFG_LAMBDA: lambda_q = val;
            CFG_DAMP:   damp_q = val;
            default:    scale_q = val;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_all();
        while (pending_words.size() > 0 || in_valid || stress_expected.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near_one();
        return 32'sd65536 + $signed(32'($urandom_range(16383))) - 32'sd8192;
    endfunction

    function automatic logic [31:0] near_zero();
        return $signed(32'($urandom_range(16383))) - 32'sd8192;
    endfunction

    // mostly plausible triangles, some raw noise and flat ones
    function automatic t_in_word random_triangle();
        t_in_word w;
        int kind;
        kind = $urandom_range(9);
        w.init_e1_x = near_one(); w.init_e1_y = near_zero();
        w.init_e2_x = near_zero(); w.init_e2_y = near_one();
        w.cur_e1_x = near_one();  w.cur_e1_y = near_zero();
        w.cur_e2_x = near_zero(); w.cur_e2_y = near_one();
        w.vel_e1_x = near_zero(); w.vel_e1_y = near_zero();
        w.vel_e2_x = near_zero(); w.vel_e2_y = near_zero();
        if (kind == 0) begin
            w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else if (kind == 1) begin
            // flat current triangle: edge 2 repeats edge 1
            w.cur_e2_x = w.cur_e1_x;
            w.cur_e2_y = w.cur_e1_y;
        end else if (kind == 2) begin
            w.vel_e1_x = $urandom; w.vel_e2_y = $urandom;
            w.cur_e1_x = $urandom >> $urandom_range(31);
        end
        return w;
    endfunction

    task automatic run_phase(int n, int idle, int stall);
        idle_pct = idle;
        stall_pct = stall;
        for (int k = 0; k < n; k++) pending_words.push_back(random_triangle());
        drain_all();
    endtask

    // ---------------- main sequence ----------------
    initial begin
        t_in_word w;
        errors = 0;
        cycles = 0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_SHEAR;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        mu_q = 0; lambda_q = 0; damp_q = 0; scale_q = 31'd65536;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words under reset material values
        pending_words.push_back('0);
        w = '0;
        w.init_e1_x = 32'sd65536; w.init_e2_y = 32'sd65536;
        w.cur_e1_x = 32'sd65536;  w.cur_e2_y = 32'sd65536;
        pending_words.push_back(w);
        drain_all();

        write_reg(CFG_SHEAR, 31'd65536);
        write_reg(CFG_LAMBDA, 31'd32768);
        write_reg(CFG_DAMP, 31'd16384);
        write_reg(CFG_SCALE, 31'd65536);
        pending_words.push_back(w);
        w.cur_e1_x = 32'sd72000; w.cur_e2_y = 32'sd60000;
        w.vel_e1_x = 32'sd4000;  w.vel_e2_x = -32'sd3000;
        pending_words.push_back(w);
        w.cur_e1_y = 32'sd9000;  w.vel_e1_y = 32'sd20000;
        pending_words.push_back(w);
        // flat initial shape only
        w.init_e2_x = w.init_e1_x; w.init_e2_y = w.init_e1_y;
        pending_words.push_back(w);
        pending_words.push_back({12{32'h80000000}});
        pending_words.push_back({12{32'h7fffffff}});
        pending_words.push_back({32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000});
        pending_words.push_back({32'h1, 32'h0, 32'h0, 32'h1, 32'h1, 32'h0, 32'h0, 32'h1,
                                 32'hffffffff, 32'h0, 32'h0, 32'hffffffff});
        pending_words.push_back({32'h7fffffff, 32'h0, 32'h0, 32'h7fffffff,
                                 32'h100, 32'h0, 32'h0, 32'h100,
                                 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff});
        for (int k = 0; k < 8; k++) pending_words.push_back(random_triangle());
        drain_all();

        run_phase(80, 0, 0);

        // extremes of the material values
        write_reg(CFG_SHEAR, 31'h7fffffff);
        write_reg(CFG_LAMBDA, 31'h7fffffff);
        write_reg(CFG_DAMP, 31'h7fffffff);
        write_reg(CFG_SCALE, 31'h7fffffff);
        run_phase(60, 84, 0);

        write_reg(CFG_SHEAR, 31'd0);
        write_reg(CFG_LAMBDA, 31'd0);
        write_reg(CFG_DAMP, 31'd0);
        write_reg(CFG_SCALE, 31'd0);
        run_phase(30, 0, 84);

        // long receiver hold-off while the sender keeps offering words
        write_reg(CFG_SHEAR, 31'($urandom));
        write_reg(CFG_LAMBDA, 31'($urandom_range(200000)));
        write_reg(CFG_DAMP, 31'($urandom_range(100000)));
        write_reg(CFG_SCALE, 31'($urandom_range(70000)));
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b1;
        for (int k = 0; k < 120; k++) pending_words.push_back(random_triangle());
        drain_all();

        write_reg(CFG_SHEAR, 31'd40000);
        write_reg(CFG_LAMBDA, 31'd90000);
        write_reg(CFG_DAMP, 31'd8000);
        write_reg(CFG_SCALE, 31'd20000);
        run_phase(60, 28, 28);
        run_phase(50, 84, 84);

        drain_all();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tcs_pkg.sv
rtl/tcs_dly.sv
rtl/tcs_dot.sv
rtl/tcs_div.sv
rtl/triangle_cauchy_stress.sv
verif/tb_triangle_cauchy_stress.sv
